@@ src/hpo_pkg.sv @@
`default_nettype none
package hpo_pkg;

  typedef struct packed {
    logic hall_level;
    logic persist_done;
  } in_item_t;

  typedef struct packed {
    logic        hall_active;
    logic        pulse_accepted;
    logic        pulse_rejected;
    logic [14:0] speed;
    logic [47:0] total_distance_um;
    logic [31:0] accepted_count;
    logic [31:0] rejected_count;
    logic        persist_due;
  } out_item_t;

  localparam logic [2:0] REG_PULSE_DIST = 3'd0;
  localparam logic [2:0] REG_DEBOUNCE   = 3'd1;
  localparam logic [2:0] REG_MAX_SPEED  = 3'd2;
  localparam logic [2:0] REG_STALE      = 3'd3;
  localparam logic [2:0] REG_PERSIST    = 3'd4;

  localparam logic [31:0] CONFIRM_MS   = 32'd3;
  localparam logic [31:0] DIST_MIN_MS  = 32'd500;
  localparam int          DIV_STEPS    = 28;

  // controller commands and datapath status
  typedef struct packed {
    logic front;    // evaluate the filter and debounce, latch the decisions
    logic div_start;
    logic div_step;
    logic finish;   // apply pulse decision, stale, persist, load result
  } cmd_t;

  typedef struct packed {
    logic need_div;
    logic div_last;
  } status_t;

endpackage
`default_nettype wire

@@ src/hpo_datapath.sv @@
`default_nettype none
module hpo_datapath (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire hpo_pkg::in_item_t in_item,
  input  wire logic              cfg_valid,
  input  wire logic [2:0]        cfg_index,
  input  wire logic [31:0]       cfg_data,
  input  wire hpo_pkg::cmd_t     cmd,
  output hpo_pkg::status_t       status,
  output hpo_pkg::out_item_t     result
);

  logic [21:0] pulse_distance_um;
  logic [9:0]  debounce_ms;
  logic [14:0] max_speed;
  logic [15:0] speed_stale_ms;
  logic [23:0] persist_interval_ms;

  logic [31:0] now_ms;
  logic        raw_active;
  logic [31:0] transition_time;
  logic        prev_filtered;
  logic [31:0] edge_time;
  logic        edge_seen;
  logic [31:0] accept_time;
  logic        accept_seen;
  logic [31:0] persist_time;
  logic [14:0] speed_reg;
  logic [47:0] distance_total;
  logic [31:0] accept_total;
  logic [31:0] reject_total;
  logic        dirty_flag;
  logic        distance_dirty_flag;

  // latched per-item decisions
  logic        filt;
  logic        is_edge;
  logic        deb_rej;
  logic        zero_delta;

  // restoring divider: dividend 28 bits, divisor up to 39 bits
  logic [27:0] quo;
  logic [27:0] dvd;
  logic [38:0] rem;
  logic [38:0] dvs;
  logic [5:0]  step;

  logic        raw;
  logic        raw_now;
  logic [31:0] tr_time;
  logic        filt_c;
  logic [31:0] delta_c;
  logic [39:0] trial;

  assign raw     = ~in_item.hall_level;
  assign raw_now = raw;
  assign tr_time = (raw != raw_active) ? now_ms : transition_time;
  assign filt_c  = raw_now && ((now_ms - tr_time) >= hpo_pkg::CONFIRM_MS);
  assign delta_c = now_ms - accept_time;
  assign trial   = {rem, dvd[27]} - {1'b0, dvs};

  assign status.need_div = is_edge && !deb_rej && accept_seen && !zero_delta;
  assign status.div_last = (step == 6'(hpo_pkg::DIV_STEPS - 1));

  always_ff @(posedge clk) begin
    if (rst) begin
      pulse_distance_um   <= 22'd2073451;
      debounce_ms         <= 10'd20;
      max_speed           <= 15'd6000;
      speed_stale_ms      <= 16'd3000;
      persist_interval_ms <= 24'd60000;
    end else if (cfg_valid) begin
      case (cfg_index)
        hpo_pkg::REG_PULSE_DIST: pulse_distance_um   <= cfg_data[21:0];
        hpo_pkg::REG_DEBOUNCE:   debounce_ms         <= cfg_data[9:0];
        hpo_pkg::REG_MAX_SPEED:  max_speed           <= cfg_data[14:0];
        hpo_pkg::REG_STALE:      speed_stale_ms      <= cfg_data[15:0];
        hpo_pkg::REG_PERSIST:    persist_interval_ms <= cfg_data[23:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.div_start) begin
      dvd  <= {6'd0, pulse_distance_um} * 28'd36;
      dvs  <= {7'd0, delta_c} * 39'd100;
      rem  <= '0;
      quo  <= '0;
      step <= '0;
    end else if (cmd.div_step) begin
      if (!trial[39]) begin
        rem <= trial[38:0];
        quo <= {quo[26:0], 1'b1};
      end else begin
        rem <= {rem[37:0], dvd[27]};
        quo <= {quo[26:0], 1'b0};
      end
      dvd  <= {dvd[26:0], 1'b0};
      step <= step + 6'd1;
    end
  end

  always_ff @(posedge clk) begin
    logic        acc;
    logic        rej;
    logic        dirty_n;
    logic        ddirty_n;
    logic [14:0] spd_n;
    logic [31:0] since;
    logic        due;
    logic [31:0] acc_t;
    logic        acc_s;
    if (rst) begin
      now_ms <= '0; raw_active <= 1'b0; transition_time <= '0;
      prev_filtered <= 1'b0; edge_time <= '0; edge_seen <= 1'b0;
      accept_time <= '0; accept_seen <= 1'b0; persist_time <= '0;
      speed_reg <= '0; distance_total <= '0; accept_total <= '0;
      reject_total <= '0; dirty_flag <= 1'b0; distance_dirty_flag <= 1'b0;
      filt <= 1'b0; is_edge <= 1'b0; deb_rej <= 1'b0; zero_delta <= 1'b0;
    end else begin
      if (cfg_valid && cfg_index <= hpo_pkg::REG_PERSIST) dirty_flag <= 1'b1;
      if (cmd.front) begin
        if (in_item.persist_done) begin
          persist_time        <= now_ms;
          dirty_flag          <= 1'b0;
          distance_dirty_flag <= 1'b0;
        end
        raw_active      <= raw;
        transition_time <= tr_time;
        filt            <= filt_c;
        is_edge         <= filt_c && !prev_filtered;
        deb_rej         <= edge_seen && ((now_ms - edge_time) < {22'd0, debounce_ms});
        zero_delta      <= (delta_c == 32'd0);
        prev_filtered   <= filt_c;
        if (filt_c && !prev_filtered) begin
          edge_time <= now_ms;
          edge_seen <= 1'b1;
        end
      end
      if (cmd.finish) begin
        acc = 1'b0; rej = 1'b0;
        dirty_n = dirty_flag; ddirty_n = distance_dirty_flag;
        spd_n = speed_reg; acc_t = accept_time; acc_s = accept_seen;
        if (is_edge) begin
          if (deb_rej || (accept_seen && zero_delta)) rej = 1'b1;
          else if (accept_seen && quo > {13'd0, max_speed}) rej = 1'b1;
          else acc = 1'b1;
          if (acc && accept_seen) spd_n = quo[14:0];
        end
        if (acc) begin
          acc_t = now_ms; acc_s = 1'b1; dirty_n = 1'b1; ddirty_n = 1'b1;
          distance_total <= distance_total + 48'(pulse_distance_um);
          accept_total   <= accept_total + 32'd1;
        end
        if (rej) reject_total <= reject_total + 32'd1;
        if (spd_n != 15'd0 && acc_s && (now_ms - acc_t) > {16'd0, speed_stale_ms})
          spd_n = '0;
        since = now_ms - persist_time;
        due = (dirty_n && persist_interval_ms != 24'd0 &&
               since >= {8'd0, persist_interval_ms}) ||
              (dirty_n && ddirty_n && since >= hpo_pkg::DIST_MIN_MS);
        speed_reg <= spd_n; accept_time <= acc_t; accept_seen <= acc_s;
        dirty_flag <= dirty_n; distance_dirty_flag <= ddirty_n;
        now_ms <= now_ms + 32'd1;
        result.hall_active       <= filt;
        result.pulse_accepted    <= acc;
        result.pulse_rejected    <= rej;
        result.speed             <= spd_n;
        result.total_distance_um <= acc ? distance_total + 48'(pulse_distance_um)
                                        : distance_total;
        result.accepted_count    <= acc ? accept_total + 32'd1 : accept_total;
        result.rejected_count    <= rej ? reject_total + 32'd1 : reject_total;
        result.persist_due       <= due;
      end
    end
  end

endmodule
`default_nettype wire

@@ src/hpo_ctrl.sv @@
`default_nettype none
module hpo_ctrl (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             in_valid,
  output logic                  in_ready,
  output logic                  out_valid,
  input  wire logic             out_ready,
  input  wire hpo_pkg::status_t status,
  output hpo_pkg::cmd_t         cmd
);

  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_CHECK  = 4'b0010,
    S_DIV    = 4'b0100,
    S_FINISH = 4'b1000
  } state_t;

  state_t state;
  state_t state_next;

  // the output register parts the sides; a waiting result only holds the finish step
  assign in_ready = (state == S_IDLE);

  always_comb begin
    state_next    = state;
    cmd           = '0;
    case (state)
      S_IDLE: begin
        if (in_valid && in_ready) begin
          cmd.front  = 1'b1;
          state_next = S_CHECK;
        end
      end
      S_CHECK: begin
        if (status.need_div) begin
          cmd.div_start = 1'b1;
          state_next    = S_DIV;
        end else begin
          state_next = S_FINISH;
        end
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (status.div_last) state_next = S_FINISH;
      end
      S_FINISH: begin
        if (!out_valid || out_ready) begin
          cmd.finish = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.finish) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

endmodule
`default_nettype wire

@@ src/hall_pulse_odometer.sv @@
`default_nettype none
// channel | direction | handshake           | payload
// in      | input     | in_valid/in_ready   | hpo_pkg::in_item_t
// out     | output    | out_valid/out_ready | hpo_pkg::out_item_t
// cfg     | input     | cfg_valid/cfg_ready | cfg_index, cfg_data
// an item runs the check and finish steps; one whose pulse needs a speed also
// runs the 28-step serial divider between them.
// synchronous reset restores register defaults and clears the odometer and control state.
// a stalled output holds its result; the next item is taken but waits in
// its finish step until the result register is free.
module hall_pulse_odometer (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire hpo_pkg::in_item_t  in_data,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output hpo_pkg::out_item_t      out_data,
  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire logic [2:0]         cfg_index,
  input  wire logic [31:0]        cfg_data
);

  hpo_pkg::cmd_t    cmd;
  hpo_pkg::status_t status;

  assign cfg_ready = 1'b1;

  hpo_ctrl u_ctrl (
    .clk, .rst, .in_valid, .in_ready, .out_valid, .out_ready, .status, .cmd
  );

  hpo_datapath u_dp (
    .clk, .rst, .in_item(in_data), .cfg_valid, .cfg_index, .cfg_data,
    .cmd, .status, .result(out_data)
  );

endmodule
`default_nettype wire

@@ src/hpo_checker.sv @@
`default_nettype none
module hpo_checker (
  input wire logic               clk,
  input wire logic               rst,
  input wire logic               in_valid,
  input wire logic               in_ready,
  input wire logic               out_valid,
  input wire logic               out_ready,
  input wire hpo_pkg::out_item_t out_data
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("output item dropped or changed while stalled");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken while an item is being processed");

  a_flags: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(out_data.pulse_accepted && out_data.pulse_rejected))
    else $error("pulse both accepted and rejected");

  a_accept_needs_active: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.pulse_accepted |-> out_data.hall_active)
    else $error("pulse accepted without active level");

endmodule

bind hall_pulse_odometer hpo_checker u_hpo_checker (
  .clk, .rst, .in_valid, .in_ready, .out_valid, .out_ready, .out_data
);
`default_nettype wire

@@ sim/tb_hall_pulse_odometer.sv @@
`default_nettype none
module tb_hall_pulse_odometer;

  logic               clk;
  logic               rst;
  logic               in_valid;
  logic               in_ready;
  hpo_pkg::in_item_t  in_data;
  logic               out_valid;
  logic               out_ready;
  hpo_pkg::out_item_t out_data;
  logic               cfg_valid;
  logic               cfg_ready;
  logic [2:0]         cfg_index;
  logic [31:0]        cfg_data;

  hall_pulse_odometer u_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // predictor copy of configuration and odometer state
  logic [21:0] m_dist_um;
  logic [9:0]  m_debounce;
  logic [14:0] m_max_speed;
  logic [15:0] m_stale;
  logic [23:0] m_persist_ivl;
  logic [31:0] m_now;
  logic        m_raw;
  logic [31:0] m_trans_t;
  logic        m_prev_filt;
  logic [31:0] m_edge_t;
  logic        m_edge_seen;
  logic [31:0] m_acc_t;
  logic        m_acc_seen;
  logic [31:0] m_persist_t;
  logic [14:0] m_speed;
  logic [47:0] m_dist_total;
  logic [31:0] m_acc_cnt;
  logic [31:0] m_rej_cnt;
  logic        m_dirty;
  logic        m_dist_dirty;

  hpo_pkg::in_item_t  tick_q[$];
  hpo_pkg::out_item_t odo_q[$];
  int        errors;
  logic      in_taken;
  int        gap_cnt;
  int        burst_cnt;
  int        hold_cnt;
  logic      hold_req;
  logic      pause_in;
  int        stall_mode;

  task automatic write_reg_model(input logic [2:0] idx, input logic [31:0] val);
    case (idx)
      hpo_pkg::REG_PULSE_DIST: m_dist_um     = val[21:0];
      hpo_pkg::REG_DEBOUNCE:   m_debounce    = val[9:0];
      hpo_pkg::REG_MAX_SPEED:  m_max_speed   = val[14:0];
      hpo_pkg::REG_STALE:      m_stale       = val[15:0];
      hpo_pkg::REG_PERSIST:    m_persist_ivl = val[23:0];
      default: ;
    endcase
    if (idx <= hpo_pkg::REG_PERSIST) m_dirty = 1'b1;
  endtask

  // returns 1 when the pulse counts, 0 when rejected
  function automatic logic judge_pulse(input logic [31:0] now);
    logic [31:0] delta;
    logic [63:0] spd;
    if (m_edge_seen && (now - m_edge_t) < {22'd0, m_debounce}) begin
      m_edge_t = now;
      m_rej_cnt++;
      return 1'b0;
    end
    m_edge_t = now;
    m_edge_seen = 1'b1;
    if (m_acc_seen) begin
      delta = now - m_acc_t;
      if (delta == 0) begin
        m_rej_cnt++;
        return 1'b0;
      end
      spd = (64'(m_dist_um) * 64'd36) / (64'(delta) * 64'd100);
      if (spd > 64'(m_max_speed)) begin
        m_rej_cnt++;
        return 1'b0;
      end
      m_speed = spd[14:0];
    end
    m_acc_cnt++;
    m_dist_total = m_dist_total + 48'(m_dist_um);
    m_acc_t = now;
    m_acc_seen = 1'b1;
    m_dirty = 1'b1;
    m_dist_dirty = 1'b1;
    return 1'b1;
  endfunction

  function automatic hpo_pkg::out_item_t odometer_tick(input hpo_pkg::in_item_t it);
    hpo_pkg::out_item_t r;
    logic [31:0] now;
    logic        raw;
    logic        filt;
    logic        ok;
    logic [31:0] since;
    now = m_now;
    raw = !it.hall_level;
    r = '0;
    if (it.persist_done) begin
      m_persist_t = now;
      m_dirty = 1'b0;
      m_dist_dirty = 1'b0;
    end
    if (raw != m_raw) begin
      m_raw = raw;
      m_trans_t = now;
    end
    filt = m_raw && (now - m_trans_t) >= hpo_pkg::CONFIRM_MS;
    if (filt && !m_prev_filt) begin
      ok = judge_pulse(now);
      r.pulse_accepted = ok;
      r.pulse_rejected = !ok;
    end
    m_prev_filt = filt;
    if (m_speed > 0 && m_acc_seen && (now - m_acc_t) > {16'd0, m_stale})
      m_speed = '0;
    since = now - m_persist_t;
    r.persist_due = (m_dirty && m_persist_ivl != 0 && since >= {8'd0, m_persist_ivl}) ||
                    (m_dirty && m_dist_dirty && since >= hpo_pkg::DIST_MIN_MS);
    r.hall_active = filt;
    r.speed = m_speed;
    r.total_distance_um = m_dist_total;
    r.accepted_count = m_acc_cnt;
    r.rejected_count = m_rej_cnt;
    m_now = now + 1;
    return r;
  endfunction

  task automatic report(input string fld, input logic [63:0] exp_v, input logic [63:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t mismatch %s expected %0d actual %0d", $time, fld, exp_v, act_v);
      errors++;
    end
  endtask

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // acceptance, prediction and checking
  always @(posedge clk) begin
    hpo_pkg::out_item_t e;
    if (!rst && out_valid && out_ready) begin
      if (odo_q.size() == 0) begin
        $display("%0t unexpected item, expected none, actual %p", $time, out_data);
        errors++;
      end else begin
        e = odo_q.pop_front();
        report("hall_active", 64'(e.hall_active), 64'(out_data.hall_active));
        report("pulse_accepted", 64'(e.pulse_accepted), 64'(out_data.pulse_accepted));
        report("pulse_rejected", 64'(e.pulse_rejected), 64'(out_data.pulse_rejected));
        report("speed", 64'(e.speed), 64'(out_data.speed));
        report("total_distance_um", 64'(e.total_distance_um),
               64'(out_data.total_distance_um));
        report("accepted_count", 64'(e.accepted_count), 64'(out_data.accepted_count));
        report("rejected_count", 64'(e.rejected_count), 64'(out_data.rejected_count));
        report("persist_due", 64'(e.persist_due), 64'(out_data.persist_due));
      end
    end
    if (!rst && in_valid && in_ready) begin
      odo_q.push_back(odometer_tick(in_data));
      in_taken = 1'b1;
    end
  end

  // sender: bursts with random gaps
  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      in_data  <= '0;
      in_taken = 1'b0;
    end else if (!in_valid || in_taken) begin
      in_taken = 1'b0;
      if (gap_cnt > 0) begin
        gap_cnt--;
        in_valid <= 1'b0;
      end else if (tick_q.size() > 0 && !pause_in) begin
        in_valid <= 1'b1;
        in_data  <= tick_q.pop_front();
        if (burst_cnt > 0) burst_cnt--;
        else begin
          burst_cnt = $urandom_range(0, 20);
          gap_cnt = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 40);
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // receiver: own stall pattern plus an occasional long hold-off
  always @(negedge clk) begin
    if (hold_req) begin
      hold_cnt = 400;
      hold_req = 1'b0;
    end
    if (rst) out_ready <= 1'b0;
    else if (hold_cnt > 0) begin
      hold_cnt--;
      out_ready <= 1'b0;
    end else begin
      if ($urandom_range(0, 63) == 0) stall_mode = $urandom_range(0, 2);
      case (stall_mode)
        0: out_ready <= 1'b1;
        1: out_ready <= ($urandom_range(0, 3) != 0);
        default: out_ready <= ($urandom_range(0, 3) == 0);
      endcase
    end
  end

  task automatic push_tick(input logic hall, input logic pdone);
    hpo_pkg::in_item_t it;
    it.hall_level = hall;
    it.persist_done = pdone;
    tick_q.push_back(it);
  endtask

  // one magnet pass: active low for lo ticks then idle high for hi ticks
  task automatic add_pass(input int lo, input int hi);
    repeat (lo) push_tick(1'b0, $urandom_range(0, 11) == 0);
    repeat (hi) push_tick(1'b1, $urandom_range(0, 11) == 0);
  endtask

  task automatic ride(input int n, input int max_hi);
    int r;
    int start;
    start = tick_q.size();
    while (tick_q.size() - start < n) begin
      r = $urandom_range(0, 9);
      if (r < 8) add_pass($urandom_range(3, 8), $urandom_range(1, max_hi));
      else if (r == 8) add_pass($urandom_range(1, 2), $urandom_range(1, 3));
      else push_tick(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
    end
  endtask

  task automatic wait_idle;
    while (tick_q.size() > 0 || in_valid || odo_q.size() > 0) @(negedge clk);
    repeat (40) @(negedge clk);
  endtask

  task automatic cfg_write(input logic [2:0] idx, input logic [31:0] val);
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    write_reg_model(idx, val);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic cfg_all(input logic [31:0] d, input logic [31:0] db, input logic [31:0] ms,
                         input logic [31:0] st, input logic [31:0] pi);
    cfg_write(hpo_pkg::REG_PULSE_DIST, d);
    cfg_write(hpo_pkg::REG_DEBOUNCE, db);
    cfg_write(hpo_pkg::REG_MAX_SPEED, ms);
    cfg_write(hpo_pkg::REG_STALE, st);
    cfg_write(hpo_pkg::REG_PERSIST, pi);
  endtask

  initial begin
    #(20 * 3000000);
    $display("tb: failure");
    $finish;
  end

  initial begin
    errors = 0; gap_cnt = 0; burst_cnt = 0; hold_cnt = 0;
    hold_req = 1'b0; pause_in = 1'b0; stall_mode = 0; in_taken = 1'b0;
    in_valid = 1'b0; in_data = '0; out_ready = 1'b0;
    cfg_valid = 1'b0; cfg_index = hpo_pkg::REG_PULSE_DIST; cfg_data = '0;
    m_dist_um = 22'd2073451; m_debounce = 10'd20; m_max_speed = 15'd6000;
    m_stale = 16'd3000; m_persist_ivl = 24'd60000;
    m_now = '0; m_raw = 1'b0; m_trans_t = '0; m_prev_filt = 1'b0;
    m_edge_t = '0; m_edge_seen = 1'b0; m_acc_t = '0; m_acc_seen = 1'b0;
    m_persist_t = '0; m_speed = '0; m_dist_total = '0; m_acc_cnt = '0;
    m_rej_cnt = '0; m_dirty = 1'b0; m_dist_dirty = 1'b0;
    rst = 1'b1;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // directed: persist without request, first edge, glitch, debounce rejects,
    // then slow accepted pulses with speed
    push_tick(1'b1, 1'b1);
    add_pass(4, 2);
    add_pass(2, 1);
    add_pass(5, 3);
    add_pass(4, 4);
    push_tick(1'b0, 1'b1);
    wait_idle();
    add_pass(4, 130);
    add_pass(4, 130);
    wait_idle();

    ride(30, 30);
    wait_idle();

    // largest distance, no debounce, high speed limit, instant stale, no periodic persist
    cfg_all(32'd4194303, 32'd0, 32'd25500, 32'd0, 32'd0);
    hold_req = 1'b1;
    ride(60, 80);
    wait_idle();

    // smallest distance, long debounce, lowest speed limit, longest timeouts
    cfg_all(32'd1, 32'd1000, 32'd1, 32'd65535, 32'd16777215);
    ride(30, 20);
    wait_idle();

    cfg_all(32'd100000, 32'd5, 32'd1000, 32'd60, 32'd40);
    pause_in = 1'b1;
    ride(60, 60);
    repeat (50) @(negedge clk);
    pause_in = 1'b0;
    wait_idle();

    cfg_all(32'd2073451, 32'd20, 32'd6000, 32'd3000, 32'd60000);
    ride(20, 40);
    wait_idle();

    if (errors == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end

endmodule
`default_nettype wire
